// ===== hdl/clkcal_pkg.sv =====
// Shared types, codes and helper functions for the clock/calendar block.
// Used by the interfaces, the tick and keypad logic, and the top level.
// No dependencies.
`default_nettype none

package clkcal_pkg;

    localparam int CNT_W  = 7;
    localparam int YEAR_W = 14;
    localparam int SLOT_W = 4;
    localparam int STAT_W = 2;
    localparam int KEY_W  = 5;
    localparam int DIG_W  = 4;

    localparam logic [CNT_W-1:0]  MAX7  = 7'd127;
    localparam logic [YEAR_W-1:0] MAX14 = 14'd16383;

    // run status codes
    localparam logic [STAT_W-1:0] ST_IDLE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_ENTRY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RUN   = 2'd2;

    // decoded key codes besides the digits 0..9
    localparam logic [DIG_W-1:0] KEY_PROG = 4'd10;
    localparam logic [DIG_W-1:0] KEY_NONE = 4'd11;

    // entry targets
    localparam logic [2:0] TGT_SEC   = 3'd0;
    localparam logic [2:0] TGT_MIN   = 3'd1;
    localparam logic [2:0] TGT_HOUR  = 3'd2;
    localparam logic [2:0] TGT_DAY   = 3'd3;
    localparam logic [2:0] TGT_MONTH = 3'd4;
    localparam logic [2:0] TGT_YEAR  = 3'd5;

    localparam logic [SLOT_W-1:0] LAST_DIGIT_SLOT = 4'd14;

    typedef struct packed {
        logic [CNT_W-1:0]  sec;
        logic [CNT_W-1:0]  min;
        logic [CNT_W-1:0]  hour;
        logic [CNT_W-1:0]  day;
        logic [CNT_W-1:0]  month;
        logic [YEAR_W-1:0] year;
        logic              am;
        logic              mil;
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
    } clkcal_state_t;

    // keypad cell to digit / program / none
    function automatic logic [DIG_W-1:0] key_decode(input logic [KEY_W-1:0] k);
        logic [DIG_W-1:0] d;
        case (k)
            5'd1:    d = 4'd1;
            5'd2:    d = 4'd2;
            5'd3:    d = 4'd3;
            5'd4:    d = KEY_PROG;
            5'd5:    d = 4'd4;
            5'd6:    d = 4'd5;
            5'd7:    d = 4'd6;
            5'd9:    d = 4'd7;
            5'd10:   d = 4'd8;
            5'd11:   d = 4'd9;
            5'd14:   d = 4'd0;
            default: d = KEY_NONE;
        endcase
        return d;
    endfunction

    // counter written by each entry slot
    function automatic logic [2:0] slot_target(input logic [SLOT_W-1:0] s);
        logic [2:0] t;
        case (s)
            4'd0, 4'd1:               t = TGT_MONTH;
            4'd2, 4'd3:               t = TGT_DAY;
            4'd4, 4'd5, 4'd6, 4'd7:   t = TGT_YEAR;
            4'd8, 4'd9:               t = TGT_HOUR;
            4'd10, 4'd11:             t = TGT_MIN;
            default:                  t = TGT_SEC;
        endcase
        return t;
    endfunction

    // place weight of each entry slot
    function automatic logic [YEAR_W-1:0] slot_weight(input logic [SLOT_W-1:0] s);
        logic [YEAR_W-1:0] w;
        case (s)
            4'd4:                                   w = 14'd1000;
            4'd5:                                   w = 14'd100;
            4'd0, 4'd2, 4'd6, 4'd8, 4'd10, 4'd12:   w = 14'd10;
            default:                                w = 14'd1;
        endcase
        return w;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add7(input logic [CNT_W-1:0] a,
                                                  input logic [YEAR_W-1:0] b);
        logic [YEAR_W:0] s;
        s = (YEAR_W+1)'(a) + (YEAR_W+1)'(b);
        return (s > (YEAR_W+1)'(MAX7)) ? MAX7 : s[CNT_W-1:0];
    endfunction

    function automatic logic [YEAR_W-1:0] sat_add14(input logic [YEAR_W-1:0] a,
                                                    input logic [YEAR_W-1:0] b);
        logic [YEAR_W:0] s;
        s = (YEAR_W+1)'(a) + (YEAR_W+1)'(b);
        return s[YEAR_W] ? MAX14 : s[YEAR_W-1:0];
    endfunction

    // days in month; anything unknown counts as 30
    function automatic logic [4:0] month_days(input logic [CNT_W-1:0] m);
        logic [4:0] n;
        case (m)
            7'd2:                                         n = 5'd28;
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12:   n = 5'd31;
            default:                                      n = 5'd30;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/clkcal_if.sv =====
// Valid/ready channel interfaces for keypad/tick input and calendar output.
// Depends on clkcal_pkg.
`default_nettype none

interface clkcal_in_if;
    logic                             valid;
    logic                             ready;
    logic                             mode;
    logic [clkcal_pkg::KEY_W-1:0]     key_index;

    modport source (output valid, output mode, output key_index, input ready);
    modport sink   (input valid, input mode, input key_index, output ready);
endinterface

interface clkcal_out_if;
    logic                              valid;
    logic                              ready;
    logic [clkcal_pkg::CNT_W-1:0]      seconds;
    logic [clkcal_pkg::CNT_W-1:0]      minutes;
    logic [clkcal_pkg::CNT_W-1:0]      hours;
    logic [clkcal_pkg::CNT_W-1:0]      day_of_month;
    logic [clkcal_pkg::CNT_W-1:0]      month_number;
    logic [clkcal_pkg::YEAR_W-1:0]     year_number;
    logic                              morning_flag;
    logic                              format_24h;
    logic [clkcal_pkg::STAT_W-1:0]     status;
    logic [clkcal_pkg::SLOT_W-1:0]     entry_position;

    modport source (output valid, output seconds, output minutes, output hours,
                    output day_of_month, output month_number, output year_number,
                    output morning_flag, output format_24h, output status,
                    output entry_position, input ready);
    modport sink   (input valid, input seconds, input minutes, input hours,
                    input day_of_month, input month_number, input year_number,
                    input morning_flag, input format_24h, input status,
                    input entry_position, output ready);
endinterface

`default_nettype wire

// ===== hdl/clkcal_tick.sv =====
// One-second advance of the running clock and calendar (combinational).
// Depends on clkcal_pkg.
`default_nettype none

module clkcal_tick (
    input  var clkcal_pkg::clkcal_state_t cur,
    output clkcal_pkg::clkcal_state_t     nxt
);

    logic [4:0] mlen;

    always_comb
    begin
        nxt  = cur;
        mlen = clkcal_pkg::month_days(cur.month);

        // seconds
        nxt.sec = clkcal_pkg::sat_add7(cur.sec, 14'd1);
        if (nxt.sec == 7'd60)
        begin
            nxt.sec = '0;
            nxt.min = clkcal_pkg::sat_add7(cur.min, 14'd1);
        end

        // minutes, checked on every tick
        if (nxt.min == 7'd60)
        begin
            nxt.min  = '0;
            nxt.hour = clkcal_pkg::sat_add7(cur.hour, 14'd1);
            if (!cur.mil)
            begin
                if (nxt.hour == 7'd12)
                begin
                    if (cur.am)
                    begin
                        nxt.am = 1'b0;
                    end
                    else
                    begin
                        nxt.am  = 1'b1;
                        nxt.day = clkcal_pkg::sat_add7(cur.day, 14'd1);
                    end
                end
                else if (nxt.hour == 7'd13)
                begin
                    nxt.hour = 7'd1;
                end
            end
            else if (nxt.hour == 7'd24)
            begin
                nxt.hour = '0;
                nxt.day  = clkcal_pkg::sat_add7(cur.day, 14'd1);
            end
        end

        // day rollover by month length of the current month
        if (nxt.day == (7'(mlen) + 7'd1))
        begin
            nxt.day   = 7'd1;
            nxt.month = clkcal_pkg::sat_add7(cur.month, 14'd1);
        end

        // month and year rollover
        if (nxt.month == 7'd13)
        begin
            nxt.month = 7'd1;
            nxt.year  = clkcal_pkg::sat_add14(cur.year, 14'd1);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/clkcal_keypad.sv =====
// Keypad event handling: key decode, program key, digit entry, format step.
// Combinational; depends on clkcal_pkg.
`default_nettype none

module clkcal_keypad (
    input  var clkcal_pkg::clkcal_state_t    cur,
    input  var logic [clkcal_pkg::KEY_W-1:0] key_index,
    output clkcal_pkg::clkcal_state_t        nxt
);

    logic [clkcal_pkg::DIG_W-1:0]  digit;
    logic [clkcal_pkg::YEAR_W-1:0] addend;
    logic [2:0]                    target;

    always_comb
    begin
        nxt    = cur;
        digit  = clkcal_pkg::key_decode(key_index);
        target = clkcal_pkg::slot_target(cur.slot);
        // digit <= 9 and weight <= 1000, so the product fits in 14 bits
        addend = 14'(digit) * clkcal_pkg::slot_weight(cur.slot);

        if (digit == clkcal_pkg::KEY_NONE)
        begin
            nxt = cur;
        end
        else if (digit == clkcal_pkg::KEY_PROG)
        begin
            // start entry: clear time and date, keep format flags
            if (cur.status != clkcal_pkg::ST_ENTRY)
            begin
                nxt.sec    = '0;
                nxt.min    = '0;
                nxt.hour   = '0;
                nxt.day    = '0;
                nxt.month  = '0;
                nxt.year   = '0;
                nxt.status = clkcal_pkg::ST_ENTRY;
                nxt.slot   = '0;
            end
        end
        else if (cur.status == clkcal_pkg::ST_ENTRY)
        begin
            if (cur.slot < clkcal_pkg::LAST_DIGIT_SLOT)
            begin
                // accumulate digit times place weight
                unique case (target)
                    clkcal_pkg::TGT_SEC:   nxt.sec   = clkcal_pkg::sat_add7(cur.sec, addend);
                    clkcal_pkg::TGT_MIN:   nxt.min   = clkcal_pkg::sat_add7(cur.min, addend);
                    clkcal_pkg::TGT_HOUR:  nxt.hour  = clkcal_pkg::sat_add7(cur.hour, addend);
                    clkcal_pkg::TGT_DAY:   nxt.day   = clkcal_pkg::sat_add7(cur.day, addend);
                    clkcal_pkg::TGT_MONTH: nxt.month = clkcal_pkg::sat_add7(cur.month, addend);
                    default:               nxt.year  = clkcal_pkg::sat_add14(cur.year, addend);
                endcase
                nxt.slot = cur.slot + 4'd1;
            end
            else
            begin
                // format step: 0 = 12h a.m., 1 = 12h p.m., else 24h
                if (digit == 4'd0)
                begin
                    nxt.mil = 1'b0;
                    nxt.am  = 1'b1;
                end
                else if (digit == 4'd1)
                begin
                    nxt.mil = 1'b0;
                    nxt.am  = 1'b0;
                end
                else
                begin
                    nxt.mil = 1'b1;
                end
                nxt.status = clkcal_pkg::ST_RUN;
                nxt.slot   = '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/clock_calendar_with_key_entry_top.sv =====
// Top level of the clock/calendar with keypad time entry.
// Depends on clkcal_pkg, clkcal_if, clkcal_tick and clkcal_keypad.
//
// Each input transaction (a one-second tick or a keypad event) produces
// exactly one output transaction carrying a snapshot of the clock state
// after that item. Throughput is one item per clock while out_ch.ready is
// high. Output valid rises once the item has passed the input register and
// then the state register, which also serves as the output register. The
// whole update is one pass through the tick or keypad logic. Ticks are
// ignored unless the clock is running. The output holds while out_ch.ready
// is low, and the input register keeps accepting while the output can drain.
`default_nettype none

module clock_calendar_with_key_entry_top (
    input  wire              clk,
    input  wire              rst_n,
    clkcal_in_if.sink        in_ch,
    clkcal_out_if.source     out_ch
);

    logic                          in_vld_reg;
    logic                          in_mode_reg;
    logic [clkcal_pkg::KEY_W-1:0]  in_key_reg;
    logic                          out_vld_reg;
    clkcal_pkg::clkcal_state_t     state_reg;
    clkcal_pkg::clkcal_state_t     state_next;
    clkcal_pkg::clkcal_state_t     tick_state;
    clkcal_pkg::clkcal_state_t     key_state;
    logic                          advance;
    logic                          in_accept;

    assign advance   = in_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready = !in_vld_reg || advance;
    assign in_accept = in_ch.valid && in_ch.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_mode_reg <= in_ch.mode;
            in_key_reg  <= in_ch.key_index;
        end
    end

    clkcal_tick u_tick (
        .cur (state_reg),
        .nxt (tick_state)
    );

    clkcal_keypad u_keypad (
        .cur       (state_reg),
        .key_index (in_key_reg),
        .nxt       (key_state)
    );

    // select the update for the held item
    always_comb
    begin
        if (in_mode_reg)
        begin
            state_next = key_state;
        end
        else if (state_reg.status == clkcal_pkg::ST_RUN)
        begin
            state_next = tick_state;
        end
        else
        begin
            state_next = state_reg;
        end
    end

    // clock state, doubles as output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg   <= state_next;
                out_vld_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid          = out_vld_reg;
    assign out_ch.seconds        = state_reg.sec;
    assign out_ch.minutes        = state_reg.min;
    assign out_ch.hours          = state_reg.hour;
    assign out_ch.day_of_month   = state_reg.day;
    assign out_ch.month_number   = state_reg.month;
    assign out_ch.year_number    = state_reg.year;
    assign out_ch.morning_flag   = state_reg.am;
    assign out_ch.format_24h     = state_reg.mil;
    assign out_ch.status         = state_reg.status;
    assign out_ch.entry_position = state_reg.slot;

endmodule

`default_nettype wire

// ===== hdl/clkcal_checker.sv =====
// Port-level checks for the clock/calendar top, bound to it below.
// Depends on clkcal_pkg and clock_calendar_with_key_entry_top.
`default_nettype none

module clkcal_checker (
    input wire                                 clk,
    input wire                                 rst_n,
    input wire                                 out_valid,
    input wire                                 out_ready,
    input wire [clkcal_pkg::CNT_W-1:0]         seconds,
    input wire [clkcal_pkg::CNT_W-1:0]         minutes,
    input wire [clkcal_pkg::CNT_W-1:0]         hours,
    input wire [clkcal_pkg::CNT_W-1:0]         day_of_month,
    input wire [clkcal_pkg::CNT_W-1:0]         month_number,
    input wire [clkcal_pkg::YEAR_W-1:0]        year_number,
    input wire                                 morning_flag,
    input wire                                 format_24h,
    input wire [clkcal_pkg::STAT_W-1:0]        status,
    input wire [clkcal_pkg::SLOT_W-1:0]        entry_position
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(seconds) && $stable(year_number)
            && $stable(status) && $stable(entry_position))
        else $error("output changed while stalled");

    // slot is zero outside entry
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != clkcal_pkg::ST_ENTRY |-> entry_position == '0)
        else $error("entry position nonzero outside entry");

    // slot never passes the format step
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_position <= clkcal_pkg::LAST_DIGIT_SLOT)
        else $error("entry position out of range");

    // before the first program key everything stays at reset
    a_uninit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == clkcal_pkg::ST_IDLE |->
            seconds == '0 && minutes == '0 && hours == '0 && day_of_month == '0
            && month_number == '0 && year_number == '0 && !morning_flag && !format_24h)
        else $error("state changed before clock was set");

endmodule

bind clock_calendar_with_key_entry_top clkcal_checker u_clkcal_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .seconds        (out_ch.seconds),
    .minutes        (out_ch.minutes),
    .hours          (out_ch.hours),
    .day_of_month   (out_ch.day_of_month),
    .month_number   (out_ch.month_number),
    .year_number    (out_ch.year_number),
    .morning_flag   (out_ch.morning_flag),
    .format_24h     (out_ch.format_24h),
    .status         (out_ch.status),
    .entry_position (out_ch.entry_position)
);

`default_nettype wire
